>>> rtl/core/i2css_pkg.sv
// ----------------------------------------------------------------------------
// i2css_pkg : shared constants for the I2C script sequencer
// Opcodes, item kinds, bus request codes and default sizes.
// ----------------------------------------------------------------------------
package i2css_pkg;

  // default sizes
  localparam int PROG_DEPTH_DEF = 64;
  localparam int RAM_BYTES_DEF  = 8;

  // stream widths
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_W      = 7;

  // item kinds (tuser)
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_EXEC   = 2'd1;
  localparam logic [1:0] ACT_BUSDN  = 2'd2;
  localparam logic [1:0] ACT_REBOOT = 2'd3;

  // bus request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // opcodes
  localparam logic [7:0] OP_HALT   = 8'd0;
  localparam logic [7:0] OP_NOP    = 8'd1;
  localparam logic [7:0] OP_STORE  = 8'd2;
  localparam logic [7:0] OP_LDBE   = 8'd3;
  localparam logic [7:0] OP_LDLE   = 8'd4;
  localparam logic [7:0] OP_SETCNT = 8'd5;
  localparam logic [7:0] OP_DECCNT = 8'd6;
  localparam logic [7:0] OP_BNZ    = 8'd7;
  localparam logic [7:0] OP_JMP    = 8'd8;
  localparam logic [7:0] OP_SETDEV = 8'd9;
  localparam logic [7:0] OP_READ   = 8'd10;
  localparam logic [7:0] OP_WRITE  = 8'd11;
  localparam logic [7:0] OP_PUB    = 8'd12;
  localparam logic [7:0] OP_DELAY  = 8'd13;

  // load targets
  localparam logic [7:0] TGT_A = 8'd0;
  localparam logic [7:0] TGT_B = 8'd1;
  localparam logic [7:0] TGT_C = 8'd2;

endpackage

>>> rtl/core/i2c_script_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_script_sequencer : scripted I2C sensor sequencer
// Runs a loaded program one instruction per execute beat and emits bus
// requests, published results and delay requests as result beats.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis_*): every beat is one item; tuser picks the kind
//    (load program word, execute one instruction, bus completion, reboot).
//  - Output stream (m_axis_*): exactly one result beat per input beat, in
//    order. The host issues the requested I2C transfer and answers with a
//    bus completion beat; execute beats sent while a transfer is pending
//    do nothing.
//  - cfg_we/cfg_wdata writes program_length; write only while idle.
//  - The result beat is registered and is valid in the cycle after the input beat.
//  - Throughput: one beat per cycle while the receiver takes results, any
//    mix of kinds back to back. The program store has one registered read
//    port that is always aimed at the pc the machine will hold next, so the
//    instruction word is ready when the next execute beat arrives.
//  - Reset (rst, synchronous) clears the machine state, program_length and
//    m_axis_tvalid; s_axis_tready is low while rst is high. The
//    program store is not cleared and must be loaded before use.
//  - A stalled receiver holds the result register; s_axis_tready drops
//    until the waiting beat is taken.
// ----------------------------------------------------------------------------
module i2c_script_sequencer
  import i2css_pkg::*;
#(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int RAM_BYTES  = RAM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // prog_addr[5:0], prog_word[37:6], bus_ok[38], bus_read_data[102:39], pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pc_now[7:0], is_halted[8], is_fault[9], bus_request[11:10],
  // bus_device[19:12], bus_length[23:20], bus_write_data[87:24],
  // publish[88], result_a[120:89], result_b[152:121],
  // result_c_raw[184:153], delay_ms[192:185], pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int AW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int RAM_W = RAM_BYTES * 8;
  localparam logic [8:0] DEPTH9 = 9'(PROG_DEPTH);
  localparam logic [8:0] RAMB9  = 9'(RAM_BYTES);

  // input fields
  logic [1:0]  action;
  logic [5:0]  prog_addr;
  logic [31:0] prog_word;
  logic        bus_ok;
  logic [63:0] bus_read_data;

  assign action        = s_axis_tuser[1:0];
  assign prog_addr     = s_axis_tdata[5:0];
  assign prog_word     = s_axis_tdata[37:6];
  assign bus_ok        = s_axis_tdata[38];
  assign bus_read_data = s_axis_tdata[102:39];

  logic accept;
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // machine state
  logic [6:0]       prog_len;
  logic [7:0]       pc, pc_next;
  logic [7:0]       cnt, cnt_next;
  logic [7:0]       dev, dev_next;
  logic [31:0]      reg_a, reg_a_next;
  logic [31:0]      reg_b, reg_b_next;
  logic [31:0]      reg_c, reg_c_next;
  logic             halted, halted_next;
  logic             faulted, faulted_next;
  logic             busy, busy_next;
  logic             is_read, is_read_next;
  logic [3:0]       pend_len, pend_len_next;
  logic [RAM_W-1:0] ram, ram_next;

  // program store, one write and one registered read port
  logic [31:0]   prog_mem [PROG_DEPTH];
  logic [31:0]   ir;
  logic          mem_we;
  logic [7:0]    waddr_full;
  logic [AW-1:0] rd_addr;

  assign waddr_full = {2'b00, prog_addr};
  assign mem_we     = accept && (action == ACT_LOAD) && ({3'b000, prog_addr} < DEPTH9);
  // aimed at word 0 during reset so the first execute after it sees pc 0
  assign rd_addr    = rst ? '0 : pc_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prog_mem[waddr_full[AW-1:0]] <= prog_word;
    end
    // read-during-write forwards the new word
    if (mem_we && (waddr_full[AW-1:0] == rd_addr)) begin
      ir <= prog_word;
    end else begin
      ir <= prog_mem[rd_addr];
    end
  end

  // instruction fields
  logic [7:0] opc, a1, a2, a3;
  assign opc = ir[31:24];
  assign a1  = ir[23:16];
  assign a2  = ir[15:8];
  assign a3  = ir[7:0];

  // scratch RAM views
  logic [63:0] ram64;
  logic [31:0] win, rev, be_val, le_val, len_mask, ld_val;
  logic [63:0] wr_data;
  logic        ld_bad, pc_bad;

  always_comb begin
    ram64    = 64'(ram);
    win      = 32'(ram64 >> {a1[2:0], 3'b000});
    rev      = {win[7:0], win[15:8], win[23:16], win[31:24]};
    be_val   = rev >> {3'd4 - a2[2:0], 3'b000};
    for (int i = 0; i < 4; i++) begin
      len_mask[8*i +: 8] = (8'(i) < a2) ? 8'hFF : 8'h00;
    end
    le_val   = win & len_mask;
    ld_val   = (opc == OP_LDBE) ? be_val : le_val;
    ld_bad   = (a2 < 8'd1) || (a2 > 8'd4) ||
               (({1'b0, a1} + {1'b0, a2}) > RAMB9) || (a3 > TGT_C);
    for (int i = 0; i < 8; i++) begin
      wr_data[8*i +: 8] = (8'(i) < a1) ? ram64[8*i +: 8] : 8'h00;
    end
    pc_bad   = ({1'b0, pc} >= {2'b00, prog_len}) || ({1'b0, pc} >= DEPTH9);
  end

  // result fields
  logic [1:0]  req;
  logic [7:0]  req_dev;
  logic [3:0]  req_len;
  logic [63:0] req_data;
  logic        pub;
  logic [31:0] res_a, res_b, res_c;
  logic [7:0]  delay;
  logic        fault_now;

  always_comb begin
    pc_next       = pc;
    cnt_next      = cnt;
    dev_next      = dev;
    reg_a_next    = reg_a;
    reg_b_next    = reg_b;
    reg_c_next    = reg_c;
    halted_next   = halted;
    faulted_next  = faulted;
    busy_next     = busy;
    is_read_next  = is_read;
    pend_len_next = pend_len;
    ram_next      = ram;
    req           = REQ_NONE;
    req_dev       = 8'd0;
    req_len       = 4'd0;
    req_data      = 64'd0;
    pub           = 1'b0;
    res_a         = 32'd0;
    res_b         = 32'd0;
    res_c         = 32'd0;
    delay         = 8'd0;
    fault_now     = 1'b0;

    if (accept) begin
      unique case (action)
        ACT_LOAD: begin
          // store write handled at the memory
        end
        ACT_EXEC: begin
          if (!halted && !busy) begin
            if (pc_bad) begin
              fault_now = 1'b1;
            end else begin
              case (opc)
                OP_HALT: halted_next = 1'b1;
                OP_NOP:  pc_next = pc + 8'd1;
                OP_STORE: begin
                  if (a2 >= RAMB9[7:0] && RAM_BYTES < 256) begin
                    fault_now = 1'b1;
                  end else begin
                    for (int i = 0; i < RAM_BYTES; i++) begin
                      if (a2 == 8'(i)) ram_next[8*i +: 8] = a1;
                    end
                    pc_next = pc + 8'd1;
                  end
                end
                OP_LDBE, OP_LDLE: begin
                  if (ld_bad) begin
                    fault_now = 1'b1;
                  end else begin
                    if (a3 == TGT_A) reg_a_next = ld_val;
                    else if (a3 == TGT_B) reg_b_next = ld_val;
                    else reg_c_next = ld_val;
                    pc_next = pc + 8'd1;
                  end
                end
                OP_SETCNT: begin
                  cnt_next = a1;
                  pc_next  = pc + 8'd1;
                end
                OP_DECCNT: begin
                  if (cnt != 8'd0) cnt_next = cnt - 8'd1;
                  pc_next = pc + 8'd1;
                end
                OP_BNZ: pc_next = (cnt != 8'd0) ? pc + a1 : pc + 8'd1;
                OP_JMP: pc_next = pc + a1;
                OP_SETDEV: begin
                  dev_next = a1;
                  pc_next  = pc + 8'd1;
                end
                OP_READ, OP_WRITE: begin
                  if ({1'b0, a1} > RAMB9) begin
                    fault_now = 1'b1;
                  end else begin
                    busy_next     = 1'b1;
                    is_read_next  = (opc == OP_READ);
                    pend_len_next = (opc == OP_READ) ? a1[3:0] : 4'd0;
                    req           = (opc == OP_READ) ? REQ_READ : REQ_WRITE;
                    req_dev       = dev;
                    req_len       = a1[3:0];
                    req_data      = (opc == OP_READ) ? 64'd0 : wr_data;
                    pc_next       = pc + 8'd1;
                  end
                end
                OP_PUB: begin
                  pub     = 1'b1;
                  res_a   = reg_a;
                  res_b   = reg_b;
                  res_c   = reg_c;
                  pc_next = pc + 8'd1;
                end
                OP_DELAY: begin
                  delay   = a1;
                  pc_next = pc + 8'd1;
                end
                default: fault_now = 1'b1;
              endcase
            end
          end
        end
        ACT_BUSDN: begin
          if (busy) begin
            if (bus_ok) begin
              if (is_read) begin
                for (int i = 0; i < RAM_BYTES; i++) begin
                  if (4'(i) < pend_len) ram_next[8*i +: 8] = bus_read_data[8*i +: 8];
                end
              end
            end else begin
              fault_now = 1'b1;
            end
            busy_next     = 1'b0;
            is_read_next  = 1'b0;
            pend_len_next = 4'd0;
          end
        end
        ACT_REBOOT: begin
          pc_next       = 8'd0;
          cnt_next      = 8'd0;
          dev_next      = 8'd0;
          reg_a_next    = 32'd0;
          reg_b_next    = 32'd0;
          reg_c_next    = 32'd0;
          halted_next   = 1'b0;
          faulted_next  = 1'b0;
          busy_next     = 1'b0;
          is_read_next  = 1'b0;
          pend_len_next = 4'd0;
          ram_next      = '0;
        end
        default: begin
        end
      endcase
      if (fault_now) begin
        halted_next  = 1'b1;
        faulted_next = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
      pc       <= '0;
      cnt      <= '0;
      dev      <= '0;
      reg_a    <= '0;
      reg_b    <= '0;
      reg_c    <= '0;
      halted   <= 1'b0;
      faulted  <= 1'b0;
      busy     <= 1'b0;
      is_read  <= 1'b0;
      pend_len <= '0;
      ram      <= '0;
    end else begin
      if (cfg_we) prog_len <= cfg_wdata;
      pc       <= pc_next;
      cnt      <= cnt_next;
      dev      <= dev_next;
      reg_a    <= reg_a_next;
      reg_b    <= reg_b_next;
      reg_c    <= reg_c_next;
      halted   <= halted_next;
      faulted  <= faulted_next;
      busy     <= busy_next;
      is_read  <= is_read_next;
      pend_len <= pend_len_next;
      ram      <= ram_next;
    end
  end

  // result register: loads on every accepted beat, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {7'd0, delay, res_c, res_b, res_a, pub, req_data, req_len,
                       req_dev, req, faulted_next, halted_next, pc_next};
    end
  end

endmodule
